// File: sv/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

  // Eight 32-bit words of chaining or working state, word 0 is the first
  typedef logic [7:0][31:0] hash_words_t;

  // Commands from the sequencer to the compression core
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  // Status from the compression core back to the sequencer
  typedef struct packed {
    logic busy;
    logic shift;
    logic done;
  } core_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LEN_FILL = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_INDEX = 3'd7;

  localparam hash_words_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [31:0] choose(logic [31:0] e, logic [31:0] f,
                                         logic [31:0] g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic logic [31:0] major(logic [31:0] a, logic [31:0] b,
                                        logic [31:0] c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

// File: sv/sha256_in_if.sv
// Input channel: one message byte or a finish command per item.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

// File: sv/sha256_out_if.sv
// Output channel: one digest word per item.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

// File: sv/sha256_sched.sv
// Message window: packs bytes into words and expands the message schedule.
module sha256_sched import sha256_pkg::*; (
  input  logic        clk,
  input  logic        push_en,
  input  logic [7:0]  push_data,
  input  logic [1:0]  lane,
  input  logic        shift,
  output logic [31:0] w_word
);

  logic [23:0] acc;
  logic [31:0] win [16];
  logic [31:0] sched_word;

  // Next schedule word from the sliding window
  assign sched_word = small_s1(win[14]) + win[9] + small_s0(win[1]) + win[0];
  assign w_word = win[0];

  // Collect bytes, shift full words in, or slide during rounds
  always_ff @(posedge clk) begin
    if (push_en) begin
      acc <= {acc[15:0], push_data};
      if (lane == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i + 1];
        end
        win[15] <= {acc, push_data};
      end
    end else if (shift) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= sched_word;
    end
  end

endmodule

// File: sv/sha256_core.sv
// Compression core: one SHA-256 round per cycle and the chaining update.
module sha256_core import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  input  logic [31:0] w_word,
  output core_stat_t  stat,
  output hash_words_t chain
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_ADD} core_state_t;

  core_state_t state;
  logic [5:0]  rnd;
  hash_words_t v;
  logic [31:0] t1;
  logic [31:0] t2;

  // Round function on the working words
  assign t1 = v[7] + big_s1(v[4]) + choose(v[4], v[5], v[6]) + ROUND_K[rnd] + w_word;
  assign t2 = big_s0(v[0]) + major(v[0], v[1], v[2]);

  assign stat.busy  = (state != C_IDLE);
  assign stat.shift = (state == C_RUN);
  assign stat.done  = (state == C_ADD);

  // Sequence rounds and fold the result into the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      chain <= INIT_H;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (ctl.init) begin
            chain <= INIT_H;
          end
          if (ctl.start) begin
            v     <= chain;
            rnd   <= '0;
            state <= C_RUN;
          end
        end
        C_RUN: begin
          v[7] <= v[6];
          v[6] <= v[5];
          v[5] <= v[4];
          v[4] <= v[3] + t1;
          v[3] <= v[2];
          v[2] <= v[1];
          v[1] <= v[0];
          v[0] <= t1 + t2;
          rnd  <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + v[i];
          end
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

// File: sv/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: byte intake, padding and digest output.
// Usage: each absorb item is accepted while the block is idle, except that the 64th byte
// of a block starts a compression which holds the input off for its 64 rounds through
// the single round unit and the chaining add, so no new byte is taken until it ends. A
// finish item feeds the 0x80 byte, the zero bytes and the eight length bytes through
// the same byte path, with one or two compressions, and then offers the eight digest
// words, word 0 first, one per accepted output item. After the last word the block is
// back in its initial state and takes the next message.
module sha256_stream_hasher import sha256_pkg::*; (
  input logic          clk,
  input logic          rst,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_LEN, S_COMP, S_OUT} state_t;

  state_t      state;
  state_t      after;
  logic [5:0]  fill;
  logic [63:0] byte_total;
  logic [63:0] len_sr;
  logic [2:0]  out_idx;

  logic        in_acc;
  logic        out_acc;
  logic        push_en;
  logic [7:0]  push_data;
  logic [31:0] w_word;
  core_ctl_t   core_ctl;
  core_stat_t  core_stat;
  hash_words_t chain;

  assign in_ch.ready = (state == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.digest_word = chain[out_idx];
  assign out_ch.word_index  = out_idx;
  assign out_ch.last_word   = (out_idx == LAST_INDEX);

  // Select the byte source and issue core commands
  always_comb begin
    push_en   = 1'b0;
    push_data = 8'h00;
    unique case (state)
      S_IDLE: begin
        push_en   = in_acc;
        push_data = in_ch.action ? PAD_BYTE : in_ch.data_byte;
      end
      S_PAD:  push_en = (fill != LEN_FILL);
      S_LEN: begin
        push_en   = 1'b1;
        push_data = len_sr[63:56];
      end
      S_COMP: push_en = 1'b0;
      S_OUT:  push_en = 1'b0;
      default: push_en = 1'b0;
    endcase
    core_ctl.start = push_en && (fill == LAST_FILL);
    core_ctl.init  = out_acc && (out_idx == LAST_INDEX);
  end

  // Sequence intake, padding, compression waits and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after      <= S_IDLE;
      fill       <= '0;
      byte_total <= '0;
      out_idx    <= '0;
    end else begin
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.action) begin
              len_sr     <= {byte_total[60:0], 3'b000};
              byte_total <= '0;
              if (core_ctl.start) begin
                state <= S_COMP;
                after <= S_PAD;
              end else begin
                state <= S_PAD;
              end
            end else begin
              byte_total <= byte_total + 64'd1;
              if (core_ctl.start) begin
                state <= S_COMP;
                after <= S_IDLE;
              end
            end
          end
        end
        S_PAD: begin
          if (fill == LEN_FILL) begin
            state <= S_LEN;
          end else if (core_ctl.start) begin
            state <= S_COMP;
            after <= S_PAD;
          end
        end
        S_LEN: begin
          len_sr <= {len_sr[55:0], 8'h00};
          if (core_ctl.start) begin
            state <= S_COMP;
            after <= S_OUT;
          end
        end
        S_COMP: begin
          if (core_stat.done) begin
            state <= after;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_idx <= out_idx + 3'd1;
            if (out_idx == LAST_INDEX) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sha256_sched u_sched (
    .clk       (clk),
    .push_en   (push_en),
    .push_data (push_data),
    .lane      (fill[1:0]),
    .shift     (core_stat.shift),
    .w_word    (w_word)
  );

  sha256_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (core_ctl),
    .w_word (w_word),
    .stat   (core_stat),
    .chain  (chain)
  );

`ifndef SYNTHESIS
  a_start_full: assert property (@(posedge clk) disable iff (rst)
    core_ctl.start |-> push_en && fill == LAST_FILL && !core_stat.busy)
    else $error("compression started without a full block");

  a_out_idle_core: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !core_stat.busy)
    else $error("digest offered while core is compressing");

  a_finish_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.action |=> state != S_IDLE)
    else $error("finish item did not start padding");

  a_clean_after_digest: assert property (@(posedge clk) disable iff (rst)
    out_acc && out_ch.last_word |=> fill == 6'd0 && byte_total == 64'd0)
    else $error("state not cleared after digest");
`endif

endmodule
